// File: hw/rtl/skvt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the sorted key/value table.
// Used by skvt_cell and sorted_key_value_table_unit; no dependencies.
package skvt_pkg;

   localparam int DEPTH      = 64;
   localparam int KEY_BITS   = 64;
   localparam int VALUE_BITS = 32;
   localparam int LEN_BITS   = 16;
   localparam int CNT_BITS   = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      ST_UPDATED  = 3'd0,
      ST_INSERTED = 3'd1,
      ST_FULL     = 3'd2,
      ST_FOUND    = 3'd3,
      ST_MISS     = 3'd4
   } status_type;

   typedef enum logic {
      S_IDLE  = 1'b0,
      S_APPLY = 1'b1
   } state_type;

   typedef enum logic [1:0] {
      CMD_HOLD   = 2'd0,
      CMD_SHIFT  = 2'd1,
      CMD_LOAD   = 2'd2,
      CMD_UPDATE = 2'd3
   } cell_cmd_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
      logic [LEN_BITS-1:0]   length;
      logic                  tomb;
   } entry_type;

   typedef struct packed {
      logic lt;
      logic eq;
   } cell_flags_type;

endpackage

// File: hw/rtl/sorted_key_value_table_unit.sv
`timescale 1ns / 1ps
// Top level of the sorted key/value table: a row of skvt_cell slots, the
// request sequencer and the result register. Depends on skvt_pkg, skvt_cell.
//
//   channel   handshake           payload
//   request   start / busy        req_operation, req_key, req_has_value,
//                                 req_value_word, req_value_length
//   result    rsp_valid (strobe)  rsp_status, rsp_is_tombstone, rsp_value_out,
//                                 rsp_length_out, rsp_entry_count
//
// Every cell compares its key against the request key in the accept cycle, and
// the cells shift, load or update in the next. The result beat shows in the
// cycle after that; a new request may be accepted in that same cycle, but
// busy holds off new requests during the apply cycle.
// Synchronous reset empties the table at once; the result strobe cannot be stalled.
module sorted_key_value_table_unit import skvt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_operation,
   input  logic [63:0] req_key,
   input  logic        req_has_value,
   input  logic [31:0] req_value_word,
   input  logic [15:0] req_value_length,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic        rsp_is_tombstone,
   output logic [31:0] rsp_value_out,
   output logic [15:0] rsp_length_out,
   output logic [6:0]  rsp_entry_count
);

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  op_get_ff;
   entry_type             new_ff;
   logic                  accept;
   logic                  apply_en;

   entry_type             cell_entry [DEPTH];
   entry_type             cell_rd    [DEPTH];
   cell_flags_type        cell_flags [DEPTH];
   cell_cmd_type          cell_cmd   [DEPTH];
   logic [DEPTH-1:0]      lt_vec;
   logic [DEPTH-1:0]      lt_below;
   logic [DEPTH-1:0]      eq_vec;
   logic                  hit;
   logic                  full;
   logic                  do_insert;
   entry_type             rd_sel;

   logic                  rsp_valid_ff;
   status_type            status_ff, status_in;
   logic                  tomb_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic [LEN_BITS-1:0]   length_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (start) state_in = S_APPLY;
         S_APPLY: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      busy     = 1'b0;
      apply_en = 1'b0;
      unique case (state_ff)
         S_IDLE:  busy = 1'b0;
         S_APPLY: begin
            busy     = 1'b1;
            apply_en = 1'b1;
         end
         default: busy = 1'b0;
      endcase
   end

   assign accept = start && !busy;

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         op_get_ff     <= req_operation;
         new_ff.key    <= KEY_BITS'(req_key);
         new_ff.tomb   <= !req_has_value;
         new_ff.value  <= req_has_value ? VALUE_BITS'(req_value_word) : '0;
         new_ff.length <= req_has_value ? LEN_BITS'(req_value_length) : '0;
      end
   end

   // row of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type prev;
      if (i == 0) begin : g_first
         assign prev = new_ff;
      end else begin : g_rest
         assign prev = cell_entry[i-1];
      end
      skvt_cell u_cell (
         .clock      (clock),
         .cmp_en     (accept),
         .cmp_key    (KEY_BITS'(req_key)),
         .occupied   (count_ff > CNT_BITS'(i)),
         .cmd        (cell_cmd[i]),
         .new_entry  (new_ff),
         .prev_entry (prev),
         .entry      (cell_entry[i]),
         .flags      (cell_flags[i]),
         .rd_entry   (cell_rd[i])
      );
      assign lt_vec[i] = cell_flags[i].lt;
      assign eq_vec[i] = cell_flags[i].eq;
   end

   assign lt_below  = {lt_vec[DEPTH-2:0], 1'b1};
   assign hit       = |eq_vec;
   assign full      = (count_ff == CNT_BITS'(DEPTH));
   assign do_insert = apply_en && !op_get_ff && !hit && !full;

   // puts update the hit slot, or if not full load at the lower bound and shift above it
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_cmd[i] = CMD_HOLD;
         if (apply_en && !op_get_ff) begin
            if (hit) begin
               if (eq_vec[i]) cell_cmd[i] = CMD_UPDATE;
            end else if (!full) begin
               if (!lt_vec[i] && lt_below[i]) begin
                  cell_cmd[i] = CMD_LOAD;
               end else if (!lt_below[i]) begin
                  cell_cmd[i] = CMD_SHIFT;
               end
            end
         end
      end
   end

   // the hit slot is the only one driving a nonzero read entry
   always_comb begin
      rd_sel = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_sel = rd_sel | cell_rd[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_insert) count_in = count_ff + CNT_BITS'(1);
   end

   always_comb begin
      if (op_get_ff) status_in = hit ? ST_FOUND : ST_MISS;
      else if (hit)  status_in = ST_UPDATED;
      else if (full) status_in = ST_FULL;
      else           status_in = ST_INSERTED;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= apply_en;
      end
   end

   always_ff @(posedge clock) begin
      if (apply_en) begin
         status_ff <= status_in;
         tomb_ff   <= op_get_ff && hit && rd_sel.tomb;
         value_ff  <= (op_get_ff && hit) ? rd_sel.value : '0;
         length_ff <= (op_get_ff && hit) ? rd_sel.length : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_is_tombstone = tomb_ff;
   assign rsp_value_out    = 32'(value_ff);
   assign rsp_length_out   = 16'(length_ff);
   assign rsp_entry_count  = 7'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("entry count above depth");

   a_eq_onehot: assert property (@(posedge clock) disable iff (reset)
      apply_en |-> $onehot0(eq_vec))
      else $error("more than one slot matches the key");

   a_lt_prefix: assert property (@(posedge clock) disable iff (reset)
      apply_en |-> (((lt_vec + DEPTH'(1)) & lt_vec) == '0))
      else $error("keys below request are not a prefix of the row");

   a_apply_beat: assert property (@(posedge clock) disable iff (reset)
      apply_en |=> rsp_valid)
      else $error("apply cycle without result beat");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_INSERTED) |-> count_ff == $past(count_ff) + CNT_BITS'(1))
      else $error("insert did not grow the table");

endmodule

// File: hw/rtl/skvt_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted table: holds an entry, compares its key with a request
// key, and on an insert takes the neighbor's or new entry. Depends on skvt_pkg.
module skvt_cell import skvt_pkg::*; (
   input  logic                clock,
   input  logic                cmp_en,
   input  logic [KEY_BITS-1:0] cmp_key,
   input  logic                occupied,
   input  cell_cmd_type        cmd,
   input  entry_type           new_entry,
   input  entry_type           prev_entry,
   output entry_type           entry,
   output cell_flags_type      flags,
   output entry_type           rd_entry
);

   entry_type      entry_ff;
   entry_type      entry_in;
   cell_flags_type flags_ff;
   cell_flags_type flags_in;

   always_comb begin
      flags_in.lt = occupied && (entry_ff.key < cmp_key);
      flags_in.eq = occupied && (entry_ff.key == cmp_key);
   end

   always_comb begin
      entry_in = entry_ff;
      unique case (cmd)
         CMD_HOLD:   entry_in = entry_ff;
         CMD_SHIFT:  entry_in = prev_entry;
         CMD_LOAD:   entry_in = new_entry;
         CMD_UPDATE: begin
            entry_in        = new_entry;
            entry_in.key    = entry_ff.key;
         end
         default:    entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (cmp_en) begin
         flags_ff <= flags_in;
      end
   end

   assign entry    = entry_ff;
   assign flags    = flags_ff;
   assign rd_entry = flags_ff.eq ? entry_ff : '0;

endmodule

// File: tb/sv/sorted_key_value_table_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of sorted_key_value_table_unit: directed and random put/get beats
// are scored against a table predictor kept in the bench. Depends on skvt_pkg and the RTL.
module sorted_key_value_table_unit_tb;
   import skvt_pkg::*;

   localparam logic OP_PUT = 1'b0;
   localparam logic OP_GET = 1'b1;
   localparam int   REPORT_LIMIT = 10;

   typedef struct {
      status_type  status;
      logic        tomb;
      logic [31:0] value;
      logic [15:0] length;
      logic [6:0]  count;
   } table_reply_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_operation;
   logic [63:0] req_key;
   logic        req_has_value;
   logic [31:0] req_value_word;
   logic [15:0] req_value_length;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic        rsp_is_tombstone;
   logic [31:0] rsp_value_out;
   logic [15:0] rsp_length_out;
   logic [6:0]  rsp_entry_count;

   logic [63:0] held_key    [DEPTH];
   logic [31:0] held_value  [DEPTH];
   logic [15:0] held_length [DEPTH];
   logic        held_tomb   [DEPTH];
   int          held_count;

   table_reply_type pending_replies[$];
   table_reply_type want_reply;
   int              mismatch_count;

   sorted_key_value_table_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_key          (req_key),
      .req_has_value    (req_has_value),
      .req_value_word   (req_value_word),
      .req_value_length (req_value_length),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_is_tombstone (rsp_is_tombstone),
      .rsp_value_out    (rsp_value_out),
      .rsp_length_out   (rsp_length_out),
      .rsp_entry_count  (rsp_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("sorted_key_value_table_unit_tb: errors");
      $finish;
   end

   function automatic void store_entry(input int slot, input logic live,
                                       input logic [31:0] vw, input logic [15:0] vl);
      held_tomb[slot]   = ~live;
      held_value[slot]  = live ? vw : 32'd0;
      held_length[slot] = live ? vl : 16'd0;
   endfunction

   function automatic table_reply_type table_lookup_update(input logic op,
                                                           input logic [63:0] key,
                                                           input logic live,
                                                           input logic [31:0] vw,
                                                           input logic [15:0] vl);
      table_reply_type r;
      int              pos;
      logic            hit;
      r.status = ST_MISS;
      r.tomb   = 1'b0;
      r.value  = 32'd0;
      r.length = 16'd0;
      pos = 0;
      for (int i = 0; i < held_count; i++)
         if (held_key[i] < key) pos++;
      hit = (pos < held_count) && (held_key[pos] == key);
      if (op == OP_GET) begin
         if (hit) begin
            r.status = ST_FOUND;
            r.tomb   = held_tomb[pos];
            if (!held_tomb[pos]) begin
               r.value  = held_value[pos];
               r.length = held_length[pos];
            end
         end
      end else if (hit) begin
         store_entry(pos, live, vw, vl);
         r.status = ST_UPDATED;
      end else if (held_count >= DEPTH) begin
         r.status = ST_FULL;
      end else begin
         for (int i = held_count; i > pos; i--) begin
            held_key[i]    = held_key[i-1];
            held_value[i]  = held_value[i-1];
            held_length[i] = held_length[i-1];
            held_tomb[i]   = held_tomb[i-1];
         end
         held_key[pos] = key;
         store_entry(pos, live, vw, vl);
         held_count++;
         r.status = ST_INSERTED;
      end
      r.count = 7'(held_count);
      return r;
   endfunction

   function automatic logic [63:0] pick_table_key();
      int          sel;
      int          idx;
      logic [63:0] k;
      sel = $urandom_range(99);
      idx = (held_count > 0) ? $urandom_range(held_count - 1) : 0;
      k   = {$urandom, $urandom};
      if (held_count > 0 && sel < 45)
         k = held_key[idx];
      else if (held_count > 0 && sel < 60)
         k = held_key[idx] + ((sel % 2) ? 64'd1 : -64'd1);
      else if (sel < 64)
         k = (sel % 2) ? '1 : '0;
      else if (sel < 74)
         k = {8'($urandom_range(97, 122)), 8'($urandom_range(97, 122)), 48'h0};
      return k;
   endfunction

   task automatic send_request(input logic op, input logic [63:0] key, input logic live,
                               input logic [31:0] vw, input logic [15:0] vl);
      @(negedge clock);
      start            <= 1'b1;
      req_operation    <= op;
      req_key          <= key;
      req_has_value    <= live;
      req_value_word   <= vw;
      req_value_length <= vl;
      do @(posedge clock); while (busy);
      pending_replies.push_back(table_lookup_update(op, key, live, vw, vl));
   endtask

   task automatic pause_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start            <= 1'b0;
         req_operation    <= 1'($urandom);
         req_key          <= {$urandom, $urandom};
         req_has_value    <= 1'($urandom);
         req_value_word   <= $urandom;
         req_value_length <= 16'($urandom);
      end
   endtask

   task automatic drain_replies();
      int guard;
      guard = 0;
      @(negedge clock);
      start <= 1'b0;
      while (pending_replies.size() != 0 && guard < 200) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic test_directed_basics();
      send_request(OP_GET, 64'd0, 1'b1, 32'd0, 16'd0);
      send_request(OP_PUT, 64'd5, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
      send_request(OP_PUT, 64'd0, 1'b1, 32'd0, 16'd0);
      send_request(OP_PUT, '1, 1'b0, 32'hDEAD_BEEF, 16'h00FF);
      send_request(OP_PUT, 64'd3, 1'b1, 32'h1234_5678, 16'd7);
      send_request(OP_GET, 64'd5, 1'b0, 32'hFFFF_FFFF, 16'hFFFF);
      send_request(OP_GET, '1, 1'b1, 32'd0, 16'd0);
      send_request(OP_GET, 64'd4, 1'b1, 32'd0, 16'd0);
      send_request(OP_PUT, 64'd5, 1'b0, 32'h5555_AAAA, 16'h8001);
      send_request(OP_GET, 64'd5, 1'b1, 32'd0, 16'd0);
      send_request(OP_PUT, 64'd5, 1'b1, 32'hA5A5_A5A5, 16'd1234);
      send_request(OP_GET, 64'd5, 1'b1, 32'd0, 16'd0);
      send_request(OP_GET, 64'd0, 1'b1, 32'd0, 16'd0);
      send_request(OP_GET, 64'h8000_0000_0000_0000, 1'b1, 32'd0, 16'd0);
      send_request(OP_PUT, 64'h6162_6300_0000_0000, 1'b1, 32'h0000_0001, 16'd3);
      send_request(OP_PUT, 64'h6162_0000_0000_0000, 1'b1, 32'h8000_0000, 16'd2);
      send_request(OP_GET, 64'h6162_6300_0000_0000, 1'b1, 32'd0, 16'd0);
      send_request(OP_GET, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 32'd0, 16'd0);
   endtask

   task automatic run_random_traffic(input int beats, input int idle_pct);
      for (int n = 0; n < beats; n++) begin
         if ($urandom_range(99) < idle_pct)
            pause_sender($urandom_range(1, 4));
         send_request(($urandom_range(99) < 40) ? OP_GET : OP_PUT, pick_table_key(),
                      ($urandom_range(99) < 75), $urandom, 16'($urandom));
      end
   endtask

   task automatic test_full_table();
      logic [63:0] fresh;
      while (held_count < DEPTH)
         send_request(OP_PUT, {$urandom, $urandom}, 1'($urandom), $urandom, 16'($urandom));
      fresh = {$urandom, $urandom};
      send_request(OP_PUT, fresh, 1'b1, $urandom, 16'($urandom));
      send_request(OP_PUT, fresh, 1'b0, $urandom, 16'($urandom));
      send_request(OP_GET, fresh, 1'b1, 32'd0, 16'd0);
      send_request(OP_PUT, held_key[0], 1'b0, 32'h1111_2222, 16'h3333);
      send_request(OP_PUT, held_key[DEPTH-1], 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
      send_request(OP_GET, held_key[DEPTH-1], 1'b1, 32'd0, 16'd0);
      send_request(OP_GET, held_key[0], 1'b1, 32'd0, 16'd0);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_replies.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result beat: status %0d count %0d", rsp_status,
                        rsp_entry_count);
         end else begin
            want_reply = pending_replies.pop_front();
            if (rsp_status !== want_reply.status || rsp_is_tombstone !== want_reply.tomb ||
                rsp_value_out !== want_reply.value || rsp_length_out !== want_reply.length ||
                rsp_entry_count !== want_reply.count) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("mismatch: want %0d %0b %h %h %0d, got %0d %0b %h %h %0d",
                           want_reply.status, want_reply.tomb, want_reply.value,
                           want_reply.length, want_reply.count, rsp_status,
                           rsp_is_tombstone, rsp_value_out, rsp_length_out,
                           rsp_entry_count);
            end
         end
      end
   end

   initial begin
      mismatch_count   = 0;
      held_count       = 0;
      reset            = 1'b1;
      start            = 1'b0;
      req_operation    = OP_PUT;
      req_key          = 64'd0;
      req_has_value    = 1'b0;
      req_value_word   = 32'd0;
      req_value_length = 16'd0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_basics();
      drain_replies();
      run_random_traffic(650, 31);
      drain_replies();
      test_full_table();
      drain_replies();
      run_random_traffic(550, 75);
      drain_replies();
      run_random_traffic(500, 0);
      drain_replies();

      if (mismatch_count == 0 && pending_replies.size() == 0)
         $display("sorted_key_value_table_unit_tb: clean");
      else
         $display("sorted_key_value_table_unit_tb: errors");
      $finish;
   end

endmodule
